/* rtl/core/hqla_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hqla_pkg
// Shared types and constants for the hierarchical queue lock arbiter.
// ----------------------------------------------------------------------------
package hqla_pkg;

  localparam int NUM_NODES_DEF = 4;
  localparam int NUM_REQ_DEF   = 64;

  localparam int NODE_W  = 4;
  localparam int REQ_W   = 6;
  localparam int LIMIT_W = 16;
  localparam int CNT_W   = 17;
  localparam int STAT_W  = 2;

  localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST = 16'd64;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic KIND_GLOBAL = 1'b0;
  localparam logic KIND_LOCAL  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_NODE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_HELD = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [NODE_W-1:0] node_id;
    logic [REQ_W-1:0]  requester_id;
  } req_t;

  typedef struct packed {
    logic              grant_valid;
    logic [REQ_W-1:0]  grant_requester;
    logic [NODE_W-1:0] grant_node;
    logic              grant_kind;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/hierarchical_queue_lock_arbiter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_queue_lock_arbiter_unit
// Two-level FIFO lock arbiter with per-node batching of local handoffs.
// ----------------------------------------------------------------------------
// Each accepted word is one acquire or release and yields exactly one result
// word. The accept cycle issues the reads of the waiter link and node holder
// memories; the commit then applies the update and loads the output register.
// A result held by m_tready low stalls the commit. batch_limit may only be
// written while no word is in flight.
module hierarchical_queue_lock_arbiter_unit import hqla_pkg::*; #(
  parameter int NUM_NODES      = NUM_NODES_DEF,
  parameter int NUM_REQUESTERS = NUM_REQ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [15:0]        s_tdata,  // node_id[3:0], requester_id[9:4]
  input  wire logic               s_tuser,  // opcode
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // grant_valid[0], grant_requester[6:1], grant_node[10:7], status[12:11]
  output logic [15:0]             m_tdata,
  output logic                    m_tuser,  // grant_kind
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [LIMIT_W-1:0] batch_limit;
  logic               issue, commit;
  req_t               req;
  res_t               res, res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit <= BATCH_LIMIT_RST;
    end else if (cfg_valid) begin
      batch_limit <= cfg_data;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign issue    = s_tvalid && s_tready;
  assign commit   = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign req.opcode       = s_tuser;
  assign req.node_id      = s_tdata[NODE_W-1:0];
  assign req.requester_id = s_tdata[NODE_W+REQ_W-1:NODE_W];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (issue) state_next = ST_EXEC;
      ST_EXEC: if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit)        m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) res_q <= res;
  end

  assign m_tdata = {3'b000, res_q.status, res_q.grant_node, res_q.grant_requester,
                    res_q.grant_valid};
  assign m_tuser = res_q.grant_kind;

  hqla_core #(
    .NUM_NODES      (NUM_NODES),
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .req         (req),
    .commit      (commit),
    .batch_limit (batch_limit),
    .res         (res)
  );

endmodule
`default_nettype wire

/* rtl/core/hqla_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hqla_core
// Lock state: waiter link and node holder memories plus per-node queue flops.
// Reads are issued when a word is accepted into registers; the update is
// applied at the later commit, when the registered read data is available.
// ----------------------------------------------------------------------------
module hqla_core import hqla_pkg::*; #(
  parameter int NUM_NODES      = NUM_NODES_DEF,
  parameter int NUM_REQUESTERS = NUM_REQ_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               issue,
  input  wire req_t               req,
  input  wire logic               commit,
  input  wire logic [LIMIT_W-1:0] batch_limit,
  output res_t                    res
);

  localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int RW = $clog2(NUM_REQUESTERS);

  // latched request
  logic          op_q;
  logic [NW-1:0] n_q;
  logic [RW-1:0] r_q;
  logic          nbad_q;
  logic          rbad_q;

  logic          n_bad;
  logic [NW-1:0] n_idx;

  // per-node state
  logic [NUM_NODES-1:0] held, held_next;
  logic [NUM_NODES-1:0] nonempty, nonempty_next;
  logic [RW-1:0]        head [NUM_NODES];
  logic [RW-1:0]        head_next [NUM_NODES];
  logic [RW-1:0]        tail [NUM_NODES];
  logic [RW-1:0]        tail_next [NUM_NODES];
  logic [CNT_W-1:0]     count [NUM_NODES];
  logic [CNT_W-1:0]     count_next [NUM_NODES];
  logic [NW-1:0]        node_link [NUM_NODES];

  // global state
  logic          gbusy, gbusy_next;
  logic          gqne, gqne_next;
  logic [NW-1:0] ghead, ghead_next;
  logic [NW-1:0] gtail, gtail_next;
  logic [NW-1:0] owner, owner_next;

  // memories
  logic [RW-1:0] waiter_link [NUM_REQUESTERS];
  logic [RW-1:0] holder_mem [NUM_NODES];
  logic [RW-1:0] wl_rd, hold_m_rd;

  logic          wl_we, hold_we, nl_we;
  logic [RW-1:0] wl_wa, wl_wd, hold_wd;
  logic [NW-1:0] nl_wa, nl_wd;

  assign n_bad = 32'(req.node_id) >= NUM_NODES;
  assign n_idx = n_bad ? '0 : req.node_id[NW-1:0];

  always_ff @(posedge clk) begin
    if (issue) begin
      op_q      <= req.opcode;
      n_q       <= n_idx;
      r_q       <= req.requester_id[RW-1:0];
      nbad_q    <= n_bad;
      rbad_q    <= 32'(req.requester_id) >= NUM_REQUESTERS;
      wl_rd     <= waiter_link[head[n_idx]];
      hold_m_rd <= holder_mem[ghead];
    end
  end

  always_ff @(posedge clk) begin
    if (commit && wl_we) begin
      waiter_link[wl_wa] <= wl_wd;
    end
    if (commit && hold_we) begin
      holder_mem[n_q] <= hold_wd;
    end
  end

  always_comb begin
    logic [CNT_W-1:0] c;
    logic [RW-1:0]    w;
    c             = count[n_q];
    w             = head[n_q];
    held_next     = held;
    nonempty_next = nonempty;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    gbusy_next    = gbusy;
    gqne_next     = gqne;
    ghead_next    = ghead;
    gtail_next    = gtail;
    owner_next    = owner;
    wl_we         = 1'b0;
    wl_wa         = tail[n_q];
    wl_wd         = r_q;
    hold_we       = 1'b0;
    hold_wd       = r_q;
    nl_we         = 1'b0;
    nl_wa         = gtail;
    nl_wd         = n_q;
    res           = '0;
    res.status    = STAT_OK;

    if (nbad_q) begin
      res.status = STAT_BAD_NODE;
    end else if (op_q == OP_ACQUIRE) begin
      if (!rbad_q) begin
        if (held[n_q]) begin
          // join the local FIFO
          if (nonempty[n_q]) begin
            wl_we = 1'b1;
          end else begin
            head_next[n_q] = r_q;
          end
          tail_next[n_q]     = r_q;
          nonempty_next[n_q] = 1'b1;
        end else begin
          held_next[n_q] = 1'b1;
          hold_we        = 1'b1;
          if (!gbusy) begin
            gbusy_next          = 1'b1;
            owner_next          = n_q;
            res.grant_valid     = 1'b1;
            res.grant_requester = REQ_W'(r_q);
            res.grant_node      = NODE_W'(n_q);
            res.grant_kind      = KIND_GLOBAL;
          end else begin
            if (gqne) nl_we = 1'b1;
            else      ghead_next = n_q;
            gtail_next = n_q;
            gqne_next  = 1'b1;
          end
        end
      end
    end else if (!gbusy || owner != n_q) begin
      res.status = STAT_NOT_HELD;
    end else if (c < {1'b0, batch_limit} && nonempty[n_q]) begin
      // local handoff, node keeps the global lock
      count_next[n_q] = CNT_W'(c + 1'b1);
      if (w == tail[n_q]) nonempty_next[n_q] = 1'b0;
      else                head_next[n_q] = wl_rd;
      hold_we             = 1'b1;
      hold_wd             = w;
      res.grant_valid     = 1'b1;
      res.grant_requester = REQ_W'(w);
      res.grant_node      = NODE_W'(n_q);
      res.grant_kind      = KIND_LOCAL;
    end else begin
      count_next[n_q] = '0;
      if (gqne) begin
        if (ghead == gtail) gqne_next = 1'b0;
        else                ghead_next = node_link[ghead];
        owner_next          = ghead;
        res.grant_valid     = 1'b1;
        res.grant_requester = REQ_W'(hold_m_rd);
        res.grant_node      = NODE_W'(ghead);
        res.grant_kind      = KIND_GLOBAL;
      end else begin
        gbusy_next = 1'b0;
      end
      if (nonempty[n_q]) begin
        // next local waiter takes the node and asks for the global lock
        if (w == tail[n_q]) nonempty_next[n_q] = 1'b0;
        else                head_next[n_q] = wl_rd;
        hold_we = 1'b1;
        hold_wd = w;
        if (!gbusy_next) begin
          gbusy_next          = 1'b1;
          owner_next          = n_q;
          res.grant_valid     = 1'b1;
          res.grant_requester = REQ_W'(w);
          res.grant_node      = NODE_W'(n_q);
          res.grant_kind      = KIND_GLOBAL;
        end else begin
          nl_wa = gtail_next;
          if (gqne_next) nl_we = 1'b1;
          else           ghead_next = n_q;
          gtail_next = n_q;
          gqne_next  = 1'b1;
        end
      end else begin
        held_next[n_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      nonempty <= '0;
      for (int i = 0; i < NUM_NODES; i++) count[i] <= '0;
      gbusy    <= 1'b0;
      gqne     <= 1'b0;
      ghead    <= '0;
      gtail    <= '0;
      owner    <= '0;
    end else if (commit) begin
      held     <= held_next;
      nonempty <= nonempty_next;
      count    <= count_next;
      gbusy    <= gbusy_next;
      gqne     <= gqne_next;
      ghead    <= ghead_next;
      gtail    <= gtail_next;
      owner    <= owner_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      head <= head_next;
      tail <= tail_next;
      if (nl_we) node_link[nl_wa] <= nl_wd;
    end
  end

`ifndef SYNTHESIS
  a_queue_needs_holder: assert property (@(posedge clk) disable iff (rst)
    (nonempty & ~held) == '0)
    else $error("local waiters on a node without a holder");

  a_gqueue_needs_busy: assert property (@(posedge clk) disable iff (rst)
    gqne |-> gbusy)
    else $error("global queue nonempty while lock free");

  a_owner_held: assert property (@(posedge clk) disable iff (rst)
    gbusy |-> held[owner])
    else $error("global owner node has no local holder");

  a_local_keeps_owner: assert property (@(posedge clk) disable iff (rst)
    commit && res.grant_valid && res.grant_kind == KIND_LOCAL
    |=> gbusy && owner == $past(n_q))
    else $error("local handoff moved the global lock");
`endif

endmodule
`default_nettype wire

/* tb/hierarchical_queue_lock_arbiter_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hierarchical_queue_lock_arbiter_unit_test
// Self-checking bench for the two-level queue lock arbiter. A shadow of the
// node queues, the global node queue and the batch counters predicts the
// result word of every accepted request. The bench runs directed sequences,
// batch_limit extremes, a long output stall and constrained-by-hand random
// lock traffic, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module hierarchical_queue_lock_arbiter_unit_test;
  import hqla_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // node_id[3:0], requester_id[9:4]
  logic              s_tuser = 1'b0; // opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // grant_valid[0], grant_requester[6:1], grant_node[10:7], status[12:11]
  logic [15:0]       m_tdata;
  logic              m_tuser;        // grant_kind
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  hierarchical_queue_lock_arbiter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the arbiter state
  bit [LIMIT_W-1:0] limit_shadow = BATCH_LIMIT_RST;
  bit [REQ_W-1:0]   waiter_next   [NUM_REQ_DEF];
  bit               cohort_held   [NUM_NODES_DEF];
  bit [REQ_W-1:0]   cohort_holder [NUM_NODES_DEF];
  bit               cohort_q_busy [NUM_NODES_DEF];
  bit [REQ_W-1:0]   cohort_q_head [NUM_NODES_DEF];
  bit [REQ_W-1:0]   cohort_q_tail [NUM_NODES_DEF];
  bit [CNT_W-1:0]   handoff_cnt   [NUM_NODES_DEF];
  bit [NODE_W-1:0]  node_next     [NUM_NODES_DEF];
  bit               lock_busy;
  bit               node_q_busy;
  bit [NODE_W-1:0]  node_q_head;
  bit [NODE_W-1:0]  node_q_tail;
  bit [NODE_W-1:0]  lock_owner;

  // requesters currently waiting or holding, a hint for the traffic generator
  bit               seated [NUM_REQ_DEF];

  res_t grant_q[$];
  int   mismatches  = 0;
  int   cycle_count = 0;
  int   hold_off_len = 0;
  bit   src_steady  = 1'b0;
  bit   sink_steady = 1'b0;

  function automatic bit [REQ_W-1:0] cohort_dequeue(input int n);
    bit [REQ_W-1:0] w;
    w = cohort_q_head[n];
    if (w == cohort_q_tail[n]) cohort_q_busy[n] = 1'b0;
    else cohort_q_head[n] = waiter_next[w];
    return w;
  endfunction

  // local holder of node n asks for the global lock; 1 if taken at once
  function automatic bit claim_global(input bit [NODE_W-1:0] n);
    if (!lock_busy) begin
      lock_busy  = 1'b1;
      lock_owner = n;
      return 1'b1;
    end
    if (node_q_busy) node_next[node_q_tail] = n;
    else node_q_head = n;
    node_q_tail = n;
    node_q_busy = 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t predict_grant(input logic op, input logic [NODE_W-1:0] node,
                                         input logic [REQ_W-1:0] req);
    res_t            r;
    int              n;
    bit [CNT_W-1:0]  c;
    bit [NODE_W-1:0] m;
    bit [REQ_W-1:0]  w;
    r = '0;
    n = int'(node);
    if (node >= NUM_NODES_DEF) begin
      r.status = STAT_BAD_NODE;
    end else if (op == OP_ACQUIRE) begin
      if (req < NUM_REQ_DEF) begin
        if (cohort_held[n]) begin
          if (cohort_q_busy[n]) waiter_next[cohort_q_tail[n]] = req;
          else cohort_q_head[n] = req;
          cohort_q_tail[n] = req;
          cohort_q_busy[n] = 1'b1;
        end else begin
          cohort_held[n]   = 1'b1;
          cohort_holder[n] = req;
          if (claim_global(node)) begin
            r.grant_valid = 1'b1; r.grant_requester = req;
            r.grant_node  = node; r.grant_kind = KIND_GLOBAL;
          end
        end
      end
    end else if (!lock_busy || lock_owner != node) begin
      r.status = STAT_NOT_HELD;
    end else begin
      c = handoff_cnt[n];
      handoff_cnt[n] = c + 1'b1;
      if (c < limit_shadow && cohort_q_busy[n]) begin
        w = cohort_dequeue(n);
        cohort_holder[n] = w;
        r.grant_valid = 1'b1; r.grant_requester = w;
        r.grant_node  = node; r.grant_kind = KIND_LOCAL;
      end else begin
        handoff_cnt[n] = '0;
        if (node_q_busy) begin
          m = node_q_head;
          if (m == node_q_tail) node_q_busy = 1'b0;
          else node_q_head = node_next[m];
          lock_owner = m;
          r.grant_valid = 1'b1; r.grant_requester = cohort_holder[m];
          r.grant_node  = m;    r.grant_kind = KIND_GLOBAL;
        end else begin
          lock_busy = 1'b0;
        end
        if (cohort_q_busy[n]) begin
          w = cohort_dequeue(n);
          cohort_holder[n] = w;
          if (claim_global(node)) begin
            r.grant_valid = 1'b1; r.grant_requester = w;
            r.grant_node  = node; r.grant_kind = KIND_GLOBAL;
          end
        end else begin
          cohort_held[n] = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Called and returns at a falling edge
  task automatic send_word(input logic op, input logic [NODE_W-1:0] node,
                           input logic [REQ_W-1:0] req);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, req, node};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    grant_q.push_back(predict_grant(op, node, req));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int count);
    int pick, node, req, start, k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      node = $urandom_range(0, NUM_NODES_DEF - 1);
      req  = $urandom_range(0, NUM_REQ_DEF - 1);
      if (pick < 8) begin
        send_word(1'($urandom_range(0, 1)), NODE_W'($urandom_range(NUM_NODES_DEF, 15)),
                  REQ_W'(req));
      end else if (pick < 14) begin
        // release from a node that does not own the lock, or while free
        if (lock_busy)
          node = (lock_owner + $urandom_range(1, NUM_NODES_DEF - 1)) % NUM_NODES_DEF;
        send_word(OP_RELEASE, NODE_W'(node), REQ_W'(req));
      end else if (pick < 18) begin
        // may repeat a queued requester
        send_word(OP_ACQUIRE, NODE_W'(node), REQ_W'(req));
      end else begin
        k = -1;
        if (!lock_busy || pick >= 58) begin
          start = $urandom_range(0, NUM_REQ_DEF - 1);
          for (int j = 0; j < NUM_REQ_DEF && k < 0; j++)
            if (!seated[(start + j) % NUM_REQ_DEF]) k = (start + j) % NUM_REQ_DEF;
        end
        if (k < 0 && lock_busy) begin
          seated[cohort_holder[lock_owner]] = 1'b0;
          send_word(OP_RELEASE, lock_owner, REQ_W'(req));
        end else begin
          if (k < 0) begin
            foreach (seated[j]) seated[j] = 1'b0;
            k = req;
          end
          seated[k] = 1'b1;
          send_word(OP_ACQUIRE, NODE_W'(node), REQ_W'(k));
        end
      end
    end
  endtask

  task automatic test_directed_ops();
    send_word(OP_ACQUIRE, 4'd0, 6'd0);
    send_word(OP_ACQUIRE, 4'd0, 6'd63);
    send_word(OP_ACQUIRE, 4'd1, 6'd5);
    send_word(OP_RELEASE, 4'd1, 6'd0);    // not the owner node
    send_word(OP_RELEASE, 4'd0, 6'd0);    // local handoff
    send_word(OP_RELEASE, 4'd0, 6'd0);    // passes to node 1
    send_word(OP_ACQUIRE, 4'd15, 6'd42);  // bad node
    send_word(OP_RELEASE, 4'd4, 6'd21);   // bad node
    send_word(OP_RELEASE, 4'd1, 6'd0);
    send_word(OP_RELEASE, 4'd1, 6'd63);   // lock already free
    send_word(OP_ACQUIRE, 4'd2, 6'd7);
    send_word(OP_ACQUIRE, 4'd2, 6'd7);    // same requester again
    send_word(OP_ACQUIRE, 4'd3, 6'd42);
    send_word(OP_RELEASE, 4'd2, 6'd0);
    send_word(OP_RELEASE, 4'd2, 6'd0);
    send_word(OP_RELEASE, 4'd3, 6'd0);
    send_word(OP_ACQUIRE, 4'd3, 6'd0);
    send_word(OP_RELEASE, 4'd3, 6'd0);
  endtask

  task automatic test_batch_limit_extremes();
    // zero: no local handoff at all, the node queue is served first
    write_limit(16'd0);
    send_word(OP_ACQUIRE, 4'd0, 6'd10);
    send_word(OP_ACQUIRE, 4'd0, 6'd11);
    send_word(OP_ACQUIRE, 4'd1, 6'd12);
    send_word(OP_RELEASE, 4'd0, 6'd0);
    send_word(OP_RELEASE, 4'd1, 6'd0);
    send_word(OP_RELEASE, 4'd0, 6'd0);
    // one handoff, then the next waiter retakes the free global lock
    write_limit(16'd1);
    send_word(OP_ACQUIRE, 4'd3, 6'd20);
    send_word(OP_ACQUIRE, 4'd3, 6'd21);
    send_word(OP_ACQUIRE, 4'd3, 6'd22);
    send_word(OP_RELEASE, 4'd3, 6'd0);
    send_word(OP_RELEASE, 4'd3, 6'd0);
    send_word(OP_RELEASE, 4'd3, 6'd0);
    write_limit(16'hFFFF);
    send_word(OP_ACQUIRE, 4'd2, 6'd30);
    send_word(OP_ACQUIRE, 4'd2, 6'd31);
    send_word(OP_RELEASE, 4'd2, 6'd0);
    send_word(OP_RELEASE, 4'd2, 6'd0);
  endtask

  // Every requester queues once behind a holder, the first one twice, so each
  // waiter link holds a value before random traffic may follow a stale link.
  task automatic test_link_fill();
    write_limit(16'hFFFF);
    send_word(OP_ACQUIRE, 4'd0, 6'd0);
    for (int r = 0; r < NUM_REQ_DEF; r++) send_word(OP_ACQUIRE, 4'd0, REQ_W'(r));
    send_word(OP_ACQUIRE, 4'd0, 6'd0);
    for (int r = 0; r < NUM_REQ_DEF + 2; r++) send_word(OP_RELEASE, 4'd0, 6'd0);
  endtask

  task automatic test_receiver_hold();
    write_limit(BATCH_LIMIT_RST);
    foreach (seated[j]) seated[j] = 1'b0;
    hold_off_len = 150;
    src_steady   = 1'b1;
    run_traffic(40);
    src_steady   = 1'b0;
  endtask

  task automatic test_random_traffic();
    write_limit(16'd0);
    run_traffic(310);
    write_limit(16'd1);
    run_traffic(310);
    write_limit(16'hFFFF);
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    run_traffic(310);
    write_limit(16'(($urandom_range(2, 6))));
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    run_traffic(310);
    write_limit(16'($urandom_range(0, 16'hFFFF)));
    run_traffic(310);
  endtask

  initial begin : grant_sink
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_off_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end
      gap = sink_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : grant_check
    res_t got, want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.grant_valid     = m_tdata[0];
      got.grant_requester = m_tdata[6:1];
      got.grant_node      = m_tdata[10:7];
      got.status          = m_tdata[12:11];
      got.grant_kind      = m_tuser;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected grant word: v=%0d req=%0d node=%0d kind=%0d st=%0d",
                   got.grant_valid, got.grant_requester, got.grant_node,
                   got.grant_kind, got.status);
      end else begin
        want = grant_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("grant mismatch: exp v=%0d req=%0d node=%0d kind=%0d st=%0d",
                     want.grant_valid, want.grant_requester, want.grant_node,
                     want.grant_kind, want.status);
            $display("                got v=%0d req=%0d node=%0d kind=%0d st=%0d",
                     got.grant_valid, got.grant_requester, got.grant_node,
                     got.grant_kind, got.status);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_ops();
    test_batch_limit_extremes();
    test_link_fill();
    test_receiver_hold();
    test_random_traffic();
    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/hqla_pkg.sv
rtl/core/hqla_core.sv
rtl/core/hierarchical_queue_lock_arbiter_unit.sv
tb/hierarchical_queue_lock_arbiter_unit_test.sv
